>>> rtl/cpu65ex_pkg.sv
// Package for the 6502 execute unit: word types, operation codes, flag positions.
// Used by every file under rtl; depends on nothing.
package cpu65ex_pkg;

	typedef enum logic [5:0] {
		KIND_ADC = 6'd0,  KIND_AND = 6'd1,  KIND_ASL = 6'd2,  KIND_BCC = 6'd3,
		KIND_BCS = 6'd4,  KIND_BEQ = 6'd5,  KIND_BIT = 6'd6,  KIND_BMI = 6'd7,
		KIND_BNE = 6'd8,  KIND_BPL = 6'd9,  KIND_BVC = 6'd10, KIND_BVS = 6'd11,
		KIND_CLC = 6'd12, KIND_CLD = 6'd13, KIND_CLI = 6'd14, KIND_CLV = 6'd15,
		KIND_CMP = 6'd16, KIND_CPX = 6'd17, KIND_CPY = 6'd18, KIND_DEC = 6'd19,
		KIND_DEX = 6'd20, KIND_DEY = 6'd21, KIND_EOR = 6'd22, KIND_INC = 6'd23,
		KIND_INX = 6'd24, KIND_INY = 6'd25, KIND_JMP = 6'd26, KIND_LDA = 6'd27,
		KIND_LDX = 6'd28, KIND_LDY = 6'd29, KIND_LSR = 6'd30, KIND_NOP = 6'd31,
		KIND_ORA = 6'd32, KIND_SBC = 6'd33, KIND_SEC = 6'd34, KIND_SED = 6'd35,
		KIND_SEI = 6'd36, KIND_STA = 6'd37, KIND_STX = 6'd38, KIND_STY = 6'd39,
		KIND_TAX = 6'd40, KIND_TAY = 6'd41, KIND_TSX = 6'd42, KIND_TXA = 6'd43,
		KIND_TXS = 6'd44, KIND_TYA = 6'd45
	} kind_t;

	// status bit positions
	localparam int unsigned FLAG_C = 0;
	localparam int unsigned FLAG_Z = 1;
	localparam int unsigned FLAG_I = 2;
	localparam int unsigned FLAG_D = 3;
	localparam int unsigned FLAG_V = 6;
	localparam int unsigned FLAG_N = 7;

	// absolute,X NOPs that take the page-cross penalty
	localparam logic [7:0] NOP_ABSX_0 = 8'h1C;
	localparam logic [7:0] NOP_ABSX_1 = 8'h3C;
	localparam logic [7:0] NOP_ABSX_2 = 8'h5C;
	localparam logic [7:0] NOP_ABSX_3 = 8'h7C;
	localparam logic [7:0] NOP_ABSX_4 = 8'hDC;
	localparam logic [7:0] NOP_ABSX_5 = 8'hFC;

	typedef struct packed {
		logic [5:0]        kind;
		logic [7:0]        opcode;
		logic [7:0]        operand;
		logic [15:0]       address;
		logic signed [7:0] rel_offset;
		logic [15:0]       next_pc;
		logic              accumulator_mode;
	} in_word_t;

	typedef struct packed {
		logic [7:0]  a_out;
		logic [7:0]  x_out;
		logic [7:0]  y_out;
		logic [7:0]  sp_out;
		logic [7:0]  status_out;
		logic [15:0] pc_out;
		logic        mem_write;
		logic [15:0] mem_addr;
		logic [7:0]  mem_data;
		logic [1:0]  extra_cycles;
		logic        may_add_cycle;
	} out_word_t;

	// architectural register set
	typedef struct packed {
		logic [7:0] a;
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] sp;
		logic [7:0] p;
	} arch_t;

	// branch request to the target unit
	typedef struct packed {
		logic              taken;
		logic [15:0]       next_pc;
		logic signed [7:0] rel_offset;
	} br_req_t;

	typedef struct packed {
		logic [15:0] target;
		logic [1:0]  extra;
	} br_rsp_t;

endpackage

>>> rtl/cpu65ex_branch.sv
// Branch target adder and taken/page-cross cycle penalty.
// Depends on cpu65ex_pkg.
module cpu65ex_branch (
	input  cpu65ex_pkg::br_req_t req,
	output cpu65ex_pkg::br_rsp_t rsp
);

	logic [15:0] offset_ext;
	logic [15:0] target;

	assign offset_ext = {{8{req.rel_offset[7]}}, req.rel_offset};
	assign target     = req.next_pc + offset_ext;

	always_comb begin
		rsp.target = target;
		if (!req.taken) begin
			rsp.extra = 2'd0;
		end else if (target[15:8] != req.next_pc[15:8]) begin
			rsp.extra = 2'd2;
		end else begin
			rsp.extra = 2'd1;
		end
	end

endmodule

>>> rtl/cpu65ex_exec.sv
// Single-pass execute logic: ALU, flag update and result word for one instruction.
// Depends on cpu65ex_pkg and cpu65ex_branch.
module cpu65ex_exec (
	input  cpu65ex_pkg::in_word_t  ins,
	input  cpu65ex_pkg::arch_t     cur,
	output cpu65ex_pkg::arch_t     nxt,
	output cpu65ex_pkg::out_word_t res
);

	cpu65ex_pkg::br_req_t br_req;
	cpu65ex_pkg::br_rsp_t br_rsp;

	logic [7:0] m;
	logic [7:0] adc_m;
	logic [8:0] sum;
	logic [7:0] shift_src;
	logic [7:0] zn_val;
	logic       zn_upd;
	logic [7:0] cmp_reg;
	logic [8:0] cmp_diff;

	assign m         = ins.operand;
	assign adc_m     = (ins.kind == cpu65ex_pkg::KIND_SBC) ? ~m : m;
	assign sum       = {1'b0, cur.a} + {1'b0, adc_m} + {8'd0, cur.p[cpu65ex_pkg::FLAG_C]};
	assign shift_src = ins.accumulator_mode ? cur.a : m;

	always_comb begin
		case (ins.kind)
			cpu65ex_pkg::KIND_CPX: cmp_reg = cur.x;
			cpu65ex_pkg::KIND_CPY: cmp_reg = cur.y;
			default:               cmp_reg = cur.a;
		endcase
	end
	// bit 8 set means borrow, i.e. reg < operand
	assign cmp_diff = {1'b0, cmp_reg} - {1'b0, m};

	// branch condition, kept apart from the result logic that reads the target back
	always_comb begin
		br_req.next_pc    = ins.next_pc;
		br_req.rel_offset = ins.rel_offset;
		case (ins.kind)
			cpu65ex_pkg::KIND_BCC: br_req.taken = ~cur.p[cpu65ex_pkg::FLAG_C];
			cpu65ex_pkg::KIND_BCS: br_req.taken =  cur.p[cpu65ex_pkg::FLAG_C];
			cpu65ex_pkg::KIND_BEQ: br_req.taken =  cur.p[cpu65ex_pkg::FLAG_Z];
			cpu65ex_pkg::KIND_BNE: br_req.taken = ~cur.p[cpu65ex_pkg::FLAG_Z];
			cpu65ex_pkg::KIND_BMI: br_req.taken =  cur.p[cpu65ex_pkg::FLAG_N];
			cpu65ex_pkg::KIND_BPL: br_req.taken = ~cur.p[cpu65ex_pkg::FLAG_N];
			cpu65ex_pkg::KIND_BVS: br_req.taken =  cur.p[cpu65ex_pkg::FLAG_V];
			cpu65ex_pkg::KIND_BVC: br_req.taken = ~cur.p[cpu65ex_pkg::FLAG_V];
			default:               br_req.taken = 1'b0;
		endcase
	end

	cpu65ex_branch u_branch (
		.req (br_req),
		.rsp (br_rsp)
	);

	always_comb begin
		nxt                 = cur;
		zn_val              = 8'd0;
		zn_upd              = 1'b0;
		res.pc_out          = ins.next_pc;
		res.mem_write       = 1'b0;
		res.mem_data        = 8'd0;
		res.may_add_cycle   = 1'b0;

		case (ins.kind)
			cpu65ex_pkg::KIND_ADC, cpu65ex_pkg::KIND_SBC: begin
				nxt.a = sum[7:0];
				nxt.p[cpu65ex_pkg::FLAG_C] = sum[8];
				nxt.p[cpu65ex_pkg::FLAG_V] = ~(cur.a[7] ^ adc_m[7]) & (cur.a[7] ^ sum[7]);
				zn_val = sum[7:0];
				zn_upd = 1'b1;
				res.may_add_cycle = 1'b1;
			end
			cpu65ex_pkg::KIND_AND: begin
				nxt.a = cur.a & m; zn_val = cur.a & m; zn_upd = 1'b1;
				res.may_add_cycle = 1'b1;
			end
			cpu65ex_pkg::KIND_ORA: begin
				nxt.a = cur.a | m; zn_val = cur.a | m; zn_upd = 1'b1;
				res.may_add_cycle = 1'b1;
			end
			cpu65ex_pkg::KIND_EOR: begin
				nxt.a = cur.a ^ m; zn_val = cur.a ^ m; zn_upd = 1'b1;
				res.may_add_cycle = 1'b1;
			end
			cpu65ex_pkg::KIND_ASL, cpu65ex_pkg::KIND_LSR: begin
				if (ins.kind == cpu65ex_pkg::KIND_ASL) begin
					nxt.p[cpu65ex_pkg::FLAG_C] = shift_src[7];
					zn_val = {shift_src[6:0], 1'b0};
				end else begin
					nxt.p[cpu65ex_pkg::FLAG_C] = shift_src[0];
					zn_val = {1'b0, shift_src[7:1]};
				end
				zn_upd = 1'b1;
				if (ins.accumulator_mode) begin
					nxt.a = zn_val;
				end else begin
					res.mem_write = 1'b1;
					res.mem_data  = zn_val;
				end
			end
			cpu65ex_pkg::KIND_BIT: begin
				nxt.p[cpu65ex_pkg::FLAG_Z] = ((cur.a & m) == 8'd0);
				nxt.p[cpu65ex_pkg::FLAG_N] = m[7];
				nxt.p[cpu65ex_pkg::FLAG_V] = m[6];
			end
			cpu65ex_pkg::KIND_CLC: nxt.p[cpu65ex_pkg::FLAG_C] = 1'b0;
			cpu65ex_pkg::KIND_CLD: nxt.p[cpu65ex_pkg::FLAG_D] = 1'b0;
			cpu65ex_pkg::KIND_CLI: nxt.p[cpu65ex_pkg::FLAG_I] = 1'b0;
			cpu65ex_pkg::KIND_CLV: nxt.p[cpu65ex_pkg::FLAG_V] = 1'b0;
			cpu65ex_pkg::KIND_SEC: nxt.p[cpu65ex_pkg::FLAG_C] = 1'b1;
			cpu65ex_pkg::KIND_SED: nxt.p[cpu65ex_pkg::FLAG_D] = 1'b1;
			cpu65ex_pkg::KIND_SEI: nxt.p[cpu65ex_pkg::FLAG_I] = 1'b1;
			cpu65ex_pkg::KIND_CMP, cpu65ex_pkg::KIND_CPX, cpu65ex_pkg::KIND_CPY: begin
				nxt.p[cpu65ex_pkg::FLAG_C] = ~cmp_diff[8];
				zn_val = cmp_diff[7:0];
				zn_upd = 1'b1;
				res.may_add_cycle = 1'b1;
			end
			cpu65ex_pkg::KIND_DEC, cpu65ex_pkg::KIND_INC: begin
				zn_val = (ins.kind == cpu65ex_pkg::KIND_INC) ? m + 8'd1 : m - 8'd1;
				zn_upd = 1'b1;
				res.mem_write = 1'b1;
				res.mem_data  = zn_val;
			end
			cpu65ex_pkg::KIND_DEX: begin nxt.x = cur.x - 8'd1; zn_val = nxt.x; zn_upd = 1'b1; end
			cpu65ex_pkg::KIND_DEY: begin nxt.y = cur.y - 8'd1; zn_val = nxt.y; zn_upd = 1'b1; end
			cpu65ex_pkg::KIND_INX: begin nxt.x = cur.x + 8'd1; zn_val = nxt.x; zn_upd = 1'b1; end
			cpu65ex_pkg::KIND_INY: begin nxt.y = cur.y + 8'd1; zn_val = nxt.y; zn_upd = 1'b1; end
			cpu65ex_pkg::KIND_JMP: res.pc_out = ins.address;
			cpu65ex_pkg::KIND_LDA: begin
				nxt.a = m; zn_val = m; zn_upd = 1'b1; res.may_add_cycle = 1'b1;
			end
			cpu65ex_pkg::KIND_LDX: begin
				nxt.x = m; zn_val = m; zn_upd = 1'b1; res.may_add_cycle = 1'b1;
			end
			cpu65ex_pkg::KIND_LDY: begin
				nxt.y = m; zn_val = m; zn_upd = 1'b1; res.may_add_cycle = 1'b1;
			end
			cpu65ex_pkg::KIND_NOP: begin
				res.may_add_cycle = ins.opcode inside {cpu65ex_pkg::NOP_ABSX_0,
					cpu65ex_pkg::NOP_ABSX_1, cpu65ex_pkg::NOP_ABSX_2,
					cpu65ex_pkg::NOP_ABSX_3, cpu65ex_pkg::NOP_ABSX_4,
					cpu65ex_pkg::NOP_ABSX_5};
			end
			cpu65ex_pkg::KIND_STA: begin res.mem_write = 1'b1; res.mem_data = cur.a; end
			cpu65ex_pkg::KIND_STX: begin res.mem_write = 1'b1; res.mem_data = cur.x; end
			cpu65ex_pkg::KIND_STY: begin res.mem_write = 1'b1; res.mem_data = cur.y; end
			cpu65ex_pkg::KIND_TAX: begin nxt.x = cur.a;  zn_val = cur.a;  zn_upd = 1'b1; end
			cpu65ex_pkg::KIND_TAY: begin nxt.y = cur.a;  zn_val = cur.a;  zn_upd = 1'b1; end
			cpu65ex_pkg::KIND_TSX: begin nxt.x = cur.sp; zn_val = cur.sp; zn_upd = 1'b1; end
			cpu65ex_pkg::KIND_TXA: begin nxt.a = cur.x;  zn_val = cur.x;  zn_upd = 1'b1; end
			cpu65ex_pkg::KIND_TYA: begin nxt.a = cur.y;  zn_val = cur.y;  zn_upd = 1'b1; end
			cpu65ex_pkg::KIND_TXS: nxt.sp = cur.x;
			default: ;
		endcase

		if (zn_upd) begin
			nxt.p[cpu65ex_pkg::FLAG_Z] = (zn_val == 8'd0);
			nxt.p[cpu65ex_pkg::FLAG_N] = zn_val[7];
		end
		if (br_req.taken) begin
			res.pc_out = br_rsp.target;
		end

		res.a_out        = nxt.a;
		res.x_out        = nxt.x;
		res.y_out        = nxt.y;
		res.sp_out       = nxt.sp;
		res.status_out   = nxt.p;
		res.mem_addr     = res.mem_write ? ins.address : 16'd0;
		res.extra_cycles = br_rsp.extra;
	end

endmodule

>>> rtl/cpu6502_instruction_execute.sv
// Top level of the 6502 execute unit: input register, execute logic, result register
// and the architectural registers A, X, Y, SP, P. Depends on cpu65ex_pkg, cpu65ex_exec.
// Pipeline: two register stages, input register (stage 1) and result register (stage 2)
// driving out_data. Throughput: one word per cycle unless out_stall holds the result; the
// input register feeds one combinational execute pass that updates A/X/Y/SP/P and loads
// the result register in the same edge.
// Reset: arst_n clears A/X/Y/SP/P and both valid bits at once; data registers are not reset.
module cpu6502_instruction_execute (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  cpu65ex_pkg::in_word_t  in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output cpu65ex_pkg::out_word_t out_data
);

	// stage 1: captured input word
	logic                   valid_s1;
	cpu65ex_pkg::in_word_t  word_s1;

	// architectural state
	cpu65ex_pkg::arch_t     arch_q;
	cpu65ex_pkg::arch_t     arch_nxt;

	// stage 2: result register
	logic                   valid_s2;
	cpu65ex_pkg::out_word_t word_s2;
	cpu65ex_pkg::out_word_t res;

	logic                   advance;

	// A word in stage 1 retires when the result register is empty or being drained.
	// The register state is only written at retirement, so each word sees the state
	// left by the one before it, even back to back.
	assign advance  = valid_s1 & (~valid_s2 | ~out_stall);
	assign in_stall = valid_s1 & ~advance;

	cpu65ex_exec u_exec (
		.ins (word_s1),
		.cur (arch_q),
		.nxt (arch_nxt),
		.res (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			word_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arch_q <= '0;
		end else if (advance) begin
			arch_q <= arch_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			word_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = word_s2;

	// A reported word with no write carries a zero address and data.
	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !word_s2.mem_write) |-> (word_s2.mem_addr == 16'd0 &&
		word_s2.mem_data == 8'd0))
		else $error("write fields nonzero without a write");

	// The branch penalty field extra_cycles never holds the value 3.
	a_extra_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (word_s2.extra_cycles != 2'd3))
		else $error("extra_cycles out of range");

	// Status bits 4 and 5 are never touched.
	a_flags_unused: assert property (@(posedge clk) disable iff (!arst_n)
		arch_q.p[5:4] == 2'b00)
		else $error("unused status bits set");

	// Registers change only when a word retires.
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(advance) |-> $stable(arch_q))
		else $error("register state changed without a retiring word");

endmodule

>>> tb/tb.sv
// Self-checking testbench for cpu6502_instruction_execute, with directed and random words.
// A shadow register file predicts each result word; handshakes on both channels are sampled to track words.
// Depends on rtl/cpu65ex_pkg.sv and rtl/cpu6502_instruction_execute.sv.
module tb;
	import cpu65ex_pkg::*;

	// kinds past TYA are unused; the block must pass them through untouched
	localparam logic [5:0] KIND_UNUSED_LO = 6'd46;
	localparam logic [5:0] KIND_UNUSED_HI = 6'd63;

	// cycles with no word moving on either side before the run is declared hung
	localparam int QUIET_LIMIT = 5000;
	// long receiver hold-off so the two-stage pipe fills and back-pressures
	localparam int HOLD_OFF_LEN = 60;
	// trailing cycles after the last result is checked, before the run ends
	localparam int DRAIN_CYCLES = 10;

	// Shadow copy of A/X/Y/SP/P plus the queue of result words still owed.
	class exec_tracker;
		logic [7:0] acc, xr, yr, sp, p;
		out_word_t  owed_results[$];
		int         mismatches;
		int         checked;

		function new();
			acc = '0;
			xr = '0;
			yr = '0;
			sp = '0;
			p = '0;
			mismatches = 0;
			checked = 0;
		endfunction

		function void set_zn(logic [7:0] v);
			p[FLAG_Z] = (v == 8'h00);
			p[FLAG_N] = v[7];
		endfunction

		function void add_carry(logic [7:0] m);
			logic [8:0] sum;
			logic [7:0] r;
			sum = {1'b0, acc} + {1'b0, m} + {8'h00, p[FLAG_C]};
			r = sum[7:0];
			p[FLAG_C] = sum[8];
			p[FLAG_V] = ~(acc[7] ^ m[7]) & (acc[7] ^ r[7]);
			acc = r;
			set_zn(r);
		endfunction

		function void compare(logic [7:0] lhs, logic [7:0] m);
			logic [7:0] d;
			d = lhs - m;
			p[FLAG_C] = (lhs >= m);
			set_zn(d);
		endfunction

		// Run one instruction on the shadow state and queue the word it must produce.
		function void note_instruction(in_word_t w);
			out_word_t  o;
			logic [7:0] r, src;
			logic [15:0] tgt;
			logic       taken;
			o = '0;
			o.pc_out = w.next_pc;
			taken = 1'b0;
			case (w.kind)
				KIND_ADC: begin add_carry(w.operand); o.may_add_cycle = 1'b1; end
				KIND_SBC: begin add_carry(~w.operand); o.may_add_cycle = 1'b1; end
				KIND_AND: begin acc = acc & w.operand; set_zn(acc); o.may_add_cycle = 1'b1; end
				KIND_ORA: begin acc = acc | w.operand; set_zn(acc); o.may_add_cycle = 1'b1; end
				KIND_EOR: begin acc = acc ^ w.operand; set_zn(acc); o.may_add_cycle = 1'b1; end
				KIND_ASL, KIND_LSR: begin
					src = w.accumulator_mode ? acc : w.operand;
					if (w.kind == KIND_ASL) begin
						p[FLAG_C] = src[7];
						r = {src[6:0], 1'b0};
					end else begin
						p[FLAG_C] = src[0];
						r = {1'b0, src[7:1]};
					end
					set_zn(r);
					if (w.accumulator_mode) begin
						acc = r;
					end else begin
						o.mem_write = 1'b1;
						o.mem_data = r;
					end
				end
				KIND_BIT: begin
					p[FLAG_Z] = ((acc & w.operand) == 8'h00);
					p[FLAG_N] = w.operand[7];
					p[FLAG_V] = w.operand[6];
				end
				KIND_BCC: taken = !p[FLAG_C];
				KIND_BCS: taken = p[FLAG_C];
				KIND_BEQ: taken = p[FLAG_Z];
				KIND_BNE: taken = !p[FLAG_Z];
				KIND_BMI: taken = p[FLAG_N];
				KIND_BPL: taken = !p[FLAG_N];
				KIND_BVC: taken = !p[FLAG_V];
				KIND_BVS: taken = p[FLAG_V];
				KIND_CLC: p[FLAG_C] = 1'b0;
				KIND_CLD: p[FLAG_D] = 1'b0;
				KIND_CLI: p[FLAG_I] = 1'b0;
				KIND_CLV: p[FLAG_V] = 1'b0;
				KIND_SEC: p[FLAG_C] = 1'b1;
				KIND_SED: p[FLAG_D] = 1'b1;
				KIND_SEI: p[FLAG_I] = 1'b1;
				KIND_CMP: begin compare(acc, w.operand); o.may_add_cycle = 1'b1; end
				KIND_CPX: begin compare(xr, w.operand); o.may_add_cycle = 1'b1; end
				KIND_CPY: begin compare(yr, w.operand); o.may_add_cycle = 1'b1; end
				KIND_DEC, KIND_INC: begin
					r = (w.kind == KIND_INC) ? w.operand + 8'd1 : w.operand - 8'd1;
					set_zn(r);
					o.mem_write = 1'b1;
					o.mem_data = r;
				end
				KIND_DEX: begin xr = xr - 8'd1; set_zn(xr); end
				KIND_DEY: begin yr = yr - 8'd1; set_zn(yr); end
				KIND_INX: begin xr = xr + 8'd1; set_zn(xr); end
				KIND_INY: begin yr = yr + 8'd1; set_zn(yr); end
				KIND_JMP: o.pc_out = w.address;
				KIND_LDA: begin acc = w.operand; set_zn(acc); o.may_add_cycle = 1'b1; end
				KIND_LDX: begin xr = w.operand; set_zn(xr); o.may_add_cycle = 1'b1; end
				KIND_LDY: begin yr = w.operand; set_zn(yr); o.may_add_cycle = 1'b1; end
				KIND_NOP: o.may_add_cycle = (w.opcode == NOP_ABSX_0) || (w.opcode == NOP_ABSX_1) ||
					(w.opcode == NOP_ABSX_2) || (w.opcode == NOP_ABSX_3) ||
					(w.opcode == NOP_ABSX_4) || (w.opcode == NOP_ABSX_5);
				KIND_STA: begin o.mem_write = 1'b1; o.mem_data = acc; end
				KIND_STX: begin o.mem_write = 1'b1; o.mem_data = xr; end
				KIND_STY: begin o.mem_write = 1'b1; o.mem_data = yr; end
				KIND_TAX: begin xr = acc; set_zn(xr); end
				KIND_TAY: begin yr = acc; set_zn(yr); end
				KIND_TSX: begin xr = sp; set_zn(xr); end
				KIND_TXA: begin acc = xr; set_zn(acc); end
				KIND_TXS: sp = xr;
				KIND_TYA: begin acc = yr; set_zn(acc); end
				default: ;
			endcase
			if (taken) begin
				tgt = w.next_pc + {{8{w.rel_offset[7]}}, w.rel_offset};
				o.pc_out = tgt;
				o.extra_cycles = (tgt[15:8] != w.next_pc[15:8]) ? 2'd2 : 2'd1;
			end
			if (o.mem_write)
				o.mem_addr = w.address;
			o.a_out = acc;
			o.x_out = xr;
			o.y_out = yr;
			o.sp_out = sp;
			o.status_out = p;
			owed_results.push_back(o);
		endfunction

		task report(string what, logic [15:0] got, logic [15:0] want);
			$display("ERROR result %0d: %s is %h, expected %h", checked, what, got, want);
			mismatches++;
		endtask

		task check_result(out_word_t got);
			out_word_t want;
			if (owed_results.size() == 0) begin
				report("unexpected word, pc_out", got.pc_out, 16'h0000);
				return;
			end
			want = owed_results.pop_front();
			if (got.a_out !== want.a_out) report("a_out", got.a_out, want.a_out);
			if (got.x_out !== want.x_out) report("x_out", got.x_out, want.x_out);
			if (got.y_out !== want.y_out) report("y_out", got.y_out, want.y_out);
			if (got.sp_out !== want.sp_out) report("sp_out", got.sp_out, want.sp_out);
			if (got.status_out !== want.status_out)
				report("status_out", got.status_out, want.status_out);
			if (got.pc_out !== want.pc_out) report("pc_out", got.pc_out, want.pc_out);
			if (got.mem_write !== want.mem_write)
				report("mem_write", got.mem_write, want.mem_write);
			if (got.mem_addr !== want.mem_addr) report("mem_addr", got.mem_addr, want.mem_addr);
			if (got.mem_data !== want.mem_data) report("mem_data", got.mem_data, want.mem_data);
			if (got.extra_cycles !== want.extra_cycles)
				report("extra_cycles", got.extra_cycles, want.extra_cycles);
			if (got.may_add_cycle !== want.may_add_cycle)
				report("may_add_cycle", got.may_add_cycle, want.may_add_cycle);
			checked++;
		endtask
	endclass

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_word_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_word_t out_data;

	exec_tracker tracker;
	int tx_idle_pct;     // chance per cycle that the sender holds valid low
	int rx_stall_pct;    // chance per cycle that the receiver raises stall
	int hold_off_cycles; // nonzero: receiver stalls this long once, then clears it
	int quiet_cycles;
	in_word_t directed_words[$];

	cpu6502_instruction_execute dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic in_word_t mk(logic [5:0] k, logic [7:0] opc, logic [7:0] opnd,
			logic [15:0] addr, logic [7:0] rel, logic [15:0] npc, logic accm);
		in_word_t w;
		w.kind = k;
		w.opcode = opc;
		w.operand = opnd;
		w.address = addr;
		w.rel_offset = rel;
		w.next_pc = npc;
		w.accumulator_mode = accm;
		return w;
	endfunction

	// Mostly real kinds, a tenth unused ones; operands lean on the byte corners now and then
	// and opcodes on the page-cross NOPs, so those rules get hit often.
	function automatic in_word_t random_word();
		in_word_t   w;
		logic [7:0] corner_bytes [5];
		logic [7:0] absx_nops [6];
		corner_bytes = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFF};
		absx_nops = '{NOP_ABSX_0, NOP_ABSX_1, NOP_ABSX_2, NOP_ABSX_3, NOP_ABSX_4, NOP_ABSX_5};
		w.kind = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI))
			: 6'($urandom_range(KIND_ADC, KIND_TYA));
		w.opcode = ($urandom_range(0, 3) == 0) ? absx_nops[$urandom_range(0, 5)] : 8'($urandom);
		w.operand = ($urandom_range(0, 7) == 0) ? corner_bytes[$urandom_range(0, 4)]
			: 8'($urandom);
		w.address = 16'($urandom);
		w.rel_offset = 8'($urandom);
		w.next_pc = 16'($urandom);
		w.accumulator_mode = 1'($urandom);
		return w;
	endfunction

	// Offer one word and return at the edge that takes it. Valid goes low only when the
	// sender decides to idle, so back-to-back words keep valid high with no glitch.
	task automatic send_word(input in_word_t w);
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (in_stall !== 1'b0);
	endtask

	task automatic send_random(input int count);
		repeat (count) send_word(random_word());
	endtask

	// Receiver: random stalls, or one long hold-off when asked, timed here in its own loop.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (hold_off_cycles) @(posedge clk);
				hold_off_cycles = 0;
			end else begin
				out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
			end
		end
	end

	// Monitor: both handshakes sampled at the edge, so values are the pre-edge ones.
	// Also the watchdog: a long run with no word moving means the block is hung.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				tracker.note_instruction(in_data);
			if (out_valid && !out_stall)
				tracker.check_result(out_data);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		tracker = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		hold_off_cycles = 0;
		quiet_cycles = 0;

		// directed words: flag corners, binary math with D set, branch page crossings
		// both ways and across the 64K wrap, the page-cross NOPs, unused kinds, stores
		// and shifts at the top address, counter wrap through zero
		directed_words.push_back(mk(KIND_LDA, 8'h00, 8'h00, 16'h0000, 8'h00, 16'h0000, 1'b0));
		directed_words.push_back(mk(KIND_LDA, 8'h00, 8'h7F, 16'h0000, 8'h00, 16'h0002, 1'b0));
		directed_words.push_back(mk(KIND_ADC, 8'h00, 8'h01, 16'h0000, 8'h00, 16'h0004, 1'b0));
		directed_words.push_back(mk(KIND_SED, 8'h00, 8'h00, 16'h0000, 8'h00, 16'h0005, 1'b0));
		directed_words.push_back(mk(KIND_ADC, 8'h00, 8'hFF, 16'h0000, 8'h00, 16'h0007, 1'b0));
		directed_words.push_back(mk(KIND_SBC, 8'h00, 8'h80, 16'h0000, 8'h00, 16'h0009, 1'b0));
		directed_words.push_back(mk(KIND_CLD, 8'h00, 8'h00, 16'h0000, 8'h00, 16'h000A, 1'b0));
		directed_words.push_back(mk(KIND_BIT, 8'h00, 8'hC0, 16'h0000, 8'h00, 16'h000C, 1'b0));
		directed_words.push_back(mk(KIND_BIT, 8'h00, 8'h3F, 16'h0000, 8'h00, 16'h000E, 1'b0));
		directed_words.push_back(mk(KIND_LSR, 8'h00, 8'hFF, 16'h1234, 8'h00, 16'h000F, 1'b1));
		directed_words.push_back(mk(KIND_ASL, 8'h00, 8'h80, 16'hFFFF, 8'h00, 16'h0011, 1'b0));
		directed_words.push_back(mk(KIND_CMP, 8'h00, 8'h00, 16'h0000, 8'h00, 16'h0013, 1'b0));
		directed_words.push_back(mk(KIND_CPX, 8'h00, 8'hFF, 16'h0000, 8'h00, 16'h0015, 1'b0));
		directed_words.push_back(mk(KIND_SEC, 8'h00, 8'h00, 16'h0000, 8'h00, 16'h0016, 1'b0));
		directed_words.push_back(mk(KIND_BCS, 8'h00, 8'h00, 16'h0000, 8'h7F, 16'h00F0, 1'b0));
		directed_words.push_back(mk(KIND_BCS, 8'h00, 8'h00, 16'h0000, 8'h80, 16'h0000, 1'b0));
		directed_words.push_back(mk(KIND_BCC, 8'h00, 8'h00, 16'h0000, 8'h10, 16'hFFFF, 1'b0));
		directed_words.push_back(mk(KIND_NOP, NOP_ABSX_0, 8'h00, 16'h0000, 8'h00, 16'h0020, 1'b0));
		directed_words.push_back(mk(KIND_NOP, NOP_ABSX_5, 8'h00, 16'h0000, 8'h00, 16'h0023, 1'b0));
		directed_words.push_back(mk(KIND_NOP, 8'hEA, 8'h00, 16'h0000, 8'h00, 16'h0024, 1'b0));
		directed_words.push_back(mk(KIND_UNUSED_HI, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b1));
		directed_words.push_back(mk(KIND_UNUSED_LO, 8'h00, 8'h00, 16'h0000, 8'h00, 16'h0025, 1'b0));
		directed_words.push_back(mk(KIND_JMP, 8'h00, 8'h00, 16'hFFFF, 8'h00, 16'h0028, 1'b0));
		directed_words.push_back(mk(KIND_DEX, 8'h00, 8'h00, 16'h0000, 8'h00, 16'h0029, 1'b0));
		directed_words.push_back(mk(KIND_TXS, 8'h00, 8'h00, 16'h0000, 8'h00, 16'h002A, 1'b0));
		directed_words.push_back(mk(KIND_TSX, 8'h00, 8'h00, 16'h0000, 8'h00, 16'h002B, 1'b0));
		directed_words.push_back(mk(KIND_INC, 8'h00, 8'hFF, 16'h8000, 8'h00, 16'h002D, 1'b0));
		directed_words.push_back(mk(KIND_STA, 8'h00, 8'h00, 16'hFFFF, 8'h00, 16'h0030, 1'b0));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// phase 1: sender mostly busy, receiver stalls hard
		tx_idle_pct = 24;
		rx_stall_pct = 80;
		foreach (directed_words[i])
			send_word(directed_words[i]);
		send_random(600);

		// phase 2: roles swapped
		tx_idle_pct = 80;
		rx_stall_pct = 24;
		send_random(600);

		// phase 3: full rate both ways, opened by a long receiver hold-off while the
		// sender keeps pushing, so the pipe fills and in_stall must rise
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		hold_off_cycles = HOLD_OFF_LEN;
		send_random(625);
		in_valid <= 1'b0;

		while (tracker.owed_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (tracker.mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
